// ===== design/ril_pkg.sv =====
// Shared types, constants and command/status structs for the ranked insertion list.
// Used by ril_ctrl, ril_datapath and ranked_insertion_list_unit.
`default_nettype none
package ril_pkg;

    // Table geometry
    localparam int ENTRIES   = 256;
    localparam int ID_BITS   = 16;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);

    // Port field widths
    localparam int CMD_W     = 2;
    localparam int PID_W     = 16;
    localparam int LOGIN_W   = 32;
    localparam int PCT_W     = 14;
    localparam int RANK_W    = 9;
    localparam int STAT_W    = 2;
    localparam int COUNT_W   = 9;

    // Identifier bits actually kept
    localparam int ID_W      = (ID_BITS < PID_W) ? ID_BITS : PID_W;

    localparam logic [PCT_W-1:0] PERCENT_MAX = PCT_W'(10000);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FIND   = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [LOGIN_W-1:0] login;
        logic [PCT_W-1:0]   pct;
    } t_entry;

    // Read address source
    typedef enum logic [2:0] {
        RA_LAST,     // count - 1
        RA_IDX_DEC2, // idx - 2
        RA_ZERO,
        RA_IDX_INC,  // idx + 1
        RA_WANT      // requested rank - 1
    } t_rd_sel;

    // Scan index update
    typedef enum logic [2:0] {
        IX_HOLD,
        IX_COUNT,
        IX_ZERO,
        IX_DEC,
        IX_INC
    } t_idx_op;

    typedef enum logic [1:0] {
        CN_HOLD,
        CN_CLEAR,
        CN_INC
    } t_cnt_op;

    typedef enum logic [1:0] {
        RK_ZERO,
        RK_IDX_INC,
        RK_WANT
    } t_rank_sel;

    // Controller -> datapath
    typedef struct packed {
        logic      capture;
        logic      rd_en;
        t_rd_sel   rd_sel;
        logic      wr_en;
        logic      wr_new;     // 1: write the new record, 0: move the record just read
        t_idx_op   idx_op;
        t_cnt_op   cnt_op;
        logic      pend_en;
        t_status   pend_status;
        t_rank_sel pend_rank;
        logic      pend_entry;
        logic      out_load;
    } t_dp_cmd;

    // Datapath -> controller
    typedef struct packed {
        t_cmd op;
        logic count_zero;
        logic full;
        logic want_ok;
        logic stop;       // record read ranks above the new one
        logic match;      // record read holds the wanted identifier
        logic last;       // scan index is the last held record
        logic idx_one;
    } t_dp_stat;

endpackage
`default_nettype wire

// ===== design/ril_datapath.sv =====
// Datapath: request capture, record memory, scan index, count and result registers.
// Depends on ril_pkg; driven by ril_ctrl through t_dp_cmd.
`default_nettype none
module ril_datapath (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire ril_pkg::t_dp_cmd         i_cmd,
    output ril_pkg::t_dp_stat             o_stat,
    input  wire logic [1:0]               i_command,
    input  wire logic [15:0]              i_player_id,
    input  wire logic [31:0]              i_login_seconds,
    input  wire logic [13:0]              i_percent_hundredths,
    input  wire logic [8:0]               i_rank_index,
    output logic [1:0]                    o_status,
    output logic [8:0]                    o_rank,
    output logic [8:0]                    o_count,
    output logic [15:0]                   o_entry_id,
    output logic [31:0]                   o_entry_login,
    output logic [13:0]                   o_entry_percent
);
    import ril_pkg::*;

    // Record memory
    t_entry mem [ENTRIES];

    t_cmd               r_op;
    t_entry             r_new;
    logic [RANK_W-1:0]  r_want;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    t_entry             r_rd_data;
    logic [ADDR_W-1:0]  rd_addr;
    t_entry             wr_data;

    t_status            r_pend_status;
    logic [RANK_W-1:0]  r_pend_rank;
    t_entry             r_pend_entry;

    logic [STAT_W-1:0]  r_out_status;
    logic [RANK_W-1:0]  r_out_rank;
    logic [COUNT_W-1:0] r_out_count;
    t_entry             r_out_entry;

    logic [PCT_W-1:0]   pct_sat;
    logic [CNT_W-1:0]   idx_ext;

    assign idx_ext = CNT_W'(r_idx);
    assign pct_sat = (i_percent_hundredths > PERCENT_MAX) ? PERCENT_MAX : i_percent_hundredths;

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op         <= t_cmd'(i_command);
            r_new.id     <= i_player_id[ID_W-1:0];
            r_new.login  <= i_login_seconds;
            r_new.pct    <= pct_sat;
            r_want       <= i_rank_index;
        end
    end

    // Read address select
    always_comb begin
        unique case (i_cmd.rd_sel)
            RA_LAST:     rd_addr = ADDR_W'(r_count - CNT_W'(1));
            RA_IDX_DEC2: rd_addr = r_idx - ADDR_W'(2);
            RA_ZERO:     rd_addr = '0;
            RA_IDX_INC:  rd_addr = r_idx + ADDR_W'(1);
            RA_WANT:     rd_addr = ADDR_W'(r_want - RANK_W'(1));
            default:     rd_addr = '0;
        endcase
    end

    assign wr_data = i_cmd.wr_new ? r_new : r_rd_data;

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[r_idx] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // Scan index and count
    always_comb begin
        unique case (i_cmd.idx_op)
            IX_HOLD:  n_idx = r_idx;
            IX_COUNT: n_idx = ADDR_W'(r_count);
            IX_ZERO:  n_idx = '0;
            IX_DEC:   n_idx = r_idx - ADDR_W'(1);
            IX_INC:   n_idx = r_idx + ADDR_W'(1);
            default:  n_idx = r_idx;
        endcase
        unique case (i_cmd.cnt_op)
            CN_HOLD:  n_count = r_count;
            CN_CLEAR: n_count = '0;
            CN_INC:   n_count = r_count + CNT_W'(1);
            default:  n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_idx <= n_idx;
    end

    // Pending result, then output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.pend_en) begin
            r_pend_status <= i_cmd.pend_status;
            unique case (i_cmd.pend_rank)
                RK_ZERO:    r_pend_rank <= '0;
                RK_IDX_INC: r_pend_rank <= RANK_W'(idx_ext + CNT_W'(1));
                RK_WANT:    r_pend_rank <= r_want;
                default:    r_pend_rank <= '0;
            endcase
            r_pend_entry <= i_cmd.pend_entry ? r_rd_data : '0;
        end
        if (i_cmd.out_load) begin
            r_out_status <= r_pend_status;
            r_out_rank   <= r_pend_rank;
            r_out_count  <= COUNT_W'(r_count);
            r_out_entry  <= r_pend_entry;
        end
    end

    // Status to controller
    always_comb begin
        o_stat.op         = r_op;
        o_stat.count_zero = (r_count == '0);
        o_stat.full       = (r_count >= CNT_W'(ENTRIES));
        o_stat.want_ok    = (r_want != '0) && (CNT_W'(r_want) <= r_count);
        o_stat.stop       = (r_rd_data.login > r_new.login);
        o_stat.match      = (r_rd_data.id == r_new.id);
        o_stat.last       = ((idx_ext + CNT_W'(1)) == r_count);
        o_stat.idx_one    = (r_idx == ADDR_W'(1));
    end

    assign o_status        = r_out_status;
    assign o_rank          = r_out_rank;
    assign o_count         = r_out_count;
    assign o_entry_id      = PID_W'(r_out_entry.id);
    assign o_entry_login   = r_out_entry.login;
    assign o_entry_percent = r_out_entry.pct;

endmodule
`default_nettype wire

// ===== design/ril_ctrl.sv =====
// Controller: sequences clear, insert, find and read requests over the datapath.
// Depends on ril_pkg; drives ril_datapath through t_dp_cmd.
`default_nettype none
module ril_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    input  wire ril_pkg::t_dp_stat i_stat,
    output ril_pkg::t_dp_cmd       o_cmd
);
    import ril_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INSERT,
        S_PLACE,
        S_FIND,
        S_READ,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    // Next state and datapath commands
    always_comb begin
        n_state           = r_state;
        n_out_valid       = r_out_valid && !i_out_ready;
        o_cmd             = '0;
        o_cmd.rd_sel      = RA_ZERO;
        o_cmd.idx_op      = IX_HOLD;
        o_cmd.cnt_op      = CN_HOLD;
        o_cmd.pend_status = ST_OK;
        o_cmd.pend_rank   = RK_ZERO;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_stat.op)
                    CMD_CLEAR: begin
                        o_cmd.cnt_op  = CN_CLEAR;
                        o_cmd.pend_en = 1'b1;
                        n_state       = S_DONE;
                    end
                    CMD_INSERT: begin
                        if (i_stat.full) begin
                            o_cmd.pend_en     = 1'b1;
                            o_cmd.pend_status = ST_FULL;
                            n_state           = S_DONE;
                        end else if (i_stat.count_zero) begin
                            o_cmd.idx_op = IX_ZERO;
                            n_state      = S_PLACE;
                        end else begin
                            o_cmd.idx_op = IX_COUNT;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RA_LAST;
                            n_state      = S_INSERT;
                        end
                    end
                    CMD_FIND: begin
                        if (i_stat.count_zero) begin
                            o_cmd.pend_en     = 1'b1;
                            o_cmd.pend_status = ST_NOT_FOUND;
                            n_state           = S_DONE;
                        end else begin
                            o_cmd.idx_op = IX_ZERO;
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RA_ZERO;
                            n_state      = S_FIND;
                        end
                    end
                    CMD_READ: begin
                        if (i_stat.want_ok) begin
                            o_cmd.rd_en  = 1'b1;
                            o_cmd.rd_sel = RA_WANT;
                            n_state      = S_READ;
                        end else begin
                            o_cmd.pend_en     = 1'b1;
                            o_cmd.pend_status = ST_RANGE;
                            n_state           = S_DONE;
                        end
                    end
                    default: n_state = S_IDLE;
                endcase
            end
            // Walk down from the end, moving each lower-ranked record up one slot
            S_INSERT: begin
                if (i_stat.stop) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.wr_en  = 1'b1;
                    o_cmd.idx_op = IX_DEC;
                    if (i_stat.idx_one) begin
                        n_state = S_PLACE;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = RA_IDX_DEC2;
                    end
                end
            end
            S_PLACE: begin
                o_cmd.wr_en     = 1'b1;
                o_cmd.wr_new    = 1'b1;
                o_cmd.cnt_op    = CN_INC;
                o_cmd.pend_en   = 1'b1;
                o_cmd.pend_rank = RK_IDX_INC;
                n_state         = S_DONE;
            end
            // Linear search from rank 1, one record per cycle
            S_FIND: begin
                if (i_stat.match) begin
                    o_cmd.pend_en   = 1'b1;
                    o_cmd.pend_rank = RK_IDX_INC;
                    n_state         = S_DONE;
                end else if (i_stat.last) begin
                    o_cmd.pend_en     = 1'b1;
                    o_cmd.pend_status = ST_NOT_FOUND;
                    n_state           = S_DONE;
                end else begin
                    o_cmd.idx_op = IX_INC;
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RA_IDX_INC;
                end
            end
            S_READ: begin
                o_cmd.pend_en    = 1'b1;
                o_cmd.pend_rank  = RK_WANT;
                o_cmd.pend_entry = 1'b1;
                n_state          = S_DONE;
            end
            // Hand the result over once the output register is free
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule
`default_nettype wire

// ===== design/ranked_insertion_list_unit.sv =====
// Ranked insertion list top: ril_ctrl and ril_datapath over ril_pkg; descending login order.
// Find time grows with the records scanned and insert time with the records moved, as the
// single-port walk handles one record at a time.
// Throughput: one request at a time; the next is taken while the previous result waits.
// Reset: count clears to zero, no result pending; record memory is not cleared.
`default_nettype none
module ranked_insertion_list_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_command,
    input  wire logic [15:0] i_player_id,
    input  wire logic [31:0] i_login_seconds,
    input  wire logic [13:0] i_percent_hundredths,
    input  wire logic [8:0]  i_rank_index,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_status,
    output logic [8:0]       o_rank,
    output logic [8:0]       o_count,
    output logic [15:0]      o_entry_id,
    output logic [31:0]      o_entry_login,
    output logic [13:0]      o_entry_percent
);
    import ril_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ril_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    ril_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (dp_cmd),
        .o_stat               (dp_stat),
        .i_command            (i_command),
        .i_player_id          (i_player_id),
        .i_login_seconds      (i_login_seconds),
        .i_percent_hundredths (i_percent_hundredths),
        .i_rank_index         (i_rank_index),
        .o_status             (o_status),
        .o_rank               (o_rank),
        .o_count              (o_count),
        .o_entry_id           (o_entry_id),
        .o_entry_login        (o_entry_login),
        .o_entry_percent      (o_entry_percent)
    );

endmodule
`default_nettype wire

// ===== dv/ranked_insertion_list_unit_test.sv =====
`timescale 1ns / 100ps
// Self-checking bench for ranked_insertion_list_unit: directed, full-table, random and
// backpressure tests against an in-bench mirror of the ranked table.
// Depends on ril_pkg and the ranked_insertion_list_unit RTL.
module ranked_insertion_list_unit_test;
    import ril_pkg::*;

    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = ENTRIES + 40;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 400;

    typedef struct {
        t_status              status;
        logic [RANK_W-1:0]    rank;
        logic [COUNT_W-1:0]   count;
        logic [PID_W-1:0]     id;
        logic [LOGIN_W-1:0]   login;
        logic [PCT_W-1:0]     pct;
    } t_outcome;

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_ready;
    logic [1:0]          i_command = '0;
    logic [15:0]         i_player_id = '0;
    logic [31:0]         i_login_seconds = '0;
    logic [13:0]         i_percent_hundredths = '0;
    logic [8:0]          i_rank_index = '0;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    logic [1:0]          o_status;
    logic [8:0]          o_rank;
    logic [8:0]          o_count;
    logic [15:0]         o_entry_id;
    logic [31:0]         o_entry_login;
    logic [13:0]         o_entry_percent;

    // Mirror of the ranked table
    logic [ID_W-1:0]     rec_id    [ENTRIES];
    logic [LOGIN_W-1:0]  rec_login [ENTRIES];
    logic [PCT_W-1:0]    rec_pct   [ENTRIES];
    int                  held_recs = 0;

    t_outcome            pending_outcomes[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int recv_hold_left = 0;
    int mismatches     = 0;
    int idle_run       = 0;
    int status_seen[4] = '{0, 0, 0, 0};
    int cmd_sent[4]    = '{0, 0, 0, 0};

    ranked_insertion_list_unit uut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_command            (i_command),
        .i_player_id          (i_player_id),
        .i_login_seconds      (i_login_seconds),
        .i_percent_hundredths (i_percent_hundredths),
        .i_rank_index         (i_rank_index),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_status             (o_status),
        .o_rank               (o_rank),
        .o_count              (o_count),
        .o_entry_id           (o_entry_id),
        .o_entry_login        (o_entry_login),
        .o_entry_percent      (o_entry_percent)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Apply one request to the mirror and return the result it must produce
    function automatic t_outcome ranked_outcome(t_cmd cmd, logic [15:0] pid,
                                                logic [31:0] login, logic [13:0] pct,
                                                logic [8:0] want);
        t_outcome r;
        int pos;
        r.status = ST_OK;
        r.rank   = '0;
        r.id     = '0;
        r.login  = '0;
        r.pct    = '0;
        case (cmd)
            CMD_CLEAR: held_recs = 0;
            CMD_INSERT: begin
                if (held_recs >= ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    // new record goes ahead of every record with login <= its own
                    while (pos < held_recs && login < rec_login[pos])
                        pos++;
                    for (int i = held_recs; i > pos; i--) begin
                        rec_id[i]    = rec_id[i-1];
                        rec_login[i] = rec_login[i-1];
                        rec_pct[i]   = rec_pct[i-1];
                    end
                    rec_id[pos]    = pid[ID_W-1:0];
                    rec_login[pos] = login;
                    rec_pct[pos]   = (pct > PERCENT_MAX) ? PERCENT_MAX : pct;
                    held_recs++;
                    r.rank = RANK_W'(pos + 1);
                end
            end
            CMD_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int i = 0; i < held_recs; i++) begin
                    if (rec_id[i] == pid[ID_W-1:0]) begin
                        r.status = ST_OK;
                        r.rank   = RANK_W'(i + 1);
                        break;
                    end
                end
            end
            default: begin
                if (want == 0 || int'(want) > held_recs) begin
                    r.status = ST_RANGE;
                end else begin
                    r.rank  = want;
                    r.id    = PID_W'(rec_id[want-1]);
                    r.login = rec_login[want-1];
                    r.pct   = rec_pct[want-1];
                end
            end
        endcase
        r.count = COUNT_W'(held_recs);
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then record the expected result.
    // Called in the time step of a rising edge; returns in the step of acceptance.
    task automatic send_request(t_cmd cmd, logic [15:0] pid, logic [31:0] login,
                                logic [13:0] pct, logic [8:0] want);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_command            <= cmd;
        i_player_id          <= pid;
        i_login_seconds      <= login;
        i_percent_hundredths <= pct;
        i_rank_index         <= want;
        @(negedge i_clk);
        while (!o_in_ready)
            @(negedge i_clk);
        @(posedge i_clk);
        pending_outcomes.push_back(ranked_outcome(cmd, pid, login, pct, want));
        cmd_sent[cmd]++;
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic finish_phase();
        i_in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    // Random request, biased toward ties, duplicate ids and ranks that exist
    task automatic send_random_request();
        t_cmd        cmd;
        logic [15:0] pid;
        logic [31:0] login;
        logic [13:0] pct;
        logic [8:0]  want;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 1)
            cmd = CMD_CLEAR;
        else if (pick < 47)
            cmd = CMD_INSERT;
        else if (pick < 67)
            cmd = CMD_FIND;
        else
            cmd = CMD_READ;

        case ($urandom_range(3))
            0: pid = 16'($urandom);
            1: pid = 16'($urandom_range(15));
            default: pid = (held_recs > 0) ? PID_W'(rec_id[$urandom_range(held_recs - 1)])
                                           : 16'($urandom);
        endcase

        case ($urandom_range(3))
            0: login = $urandom;
            1: login = 32'($urandom_range(7));
            2: login = (held_recs > 0) ? rec_login[$urandom_range(held_recs - 1)] : 32'd0;
            default: begin
                case ($urandom_range(2))
                    0: login = 32'h0000_0000;
                    1: login = 32'hFFFF_FFFF;
                    default: login = 32'h8000_0000;
                endcase
            end
        endcase

        // occasional values above the 10000 ceiling
        pct = ($urandom_range(9) == 0) ? 14'($urandom) : 14'($urandom_range(10000));

        case ($urandom_range(7))
            0: want = 9'($urandom);
            1: want = '0;
            2: want = 9'(held_recs + 1);
            default: want = (held_recs > 0) ? 9'($urandom_range(held_recs, 1)) : 9'd1;
        endcase

        send_request(cmd, pid, login, pct, want);
    endtask

    // Extremes of each field, ties at both ends, saturation, empty and out-of-range reads
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd1);
        send_request(CMD_FIND,   16'h0000, 32'h0,         14'd0,     9'd0);
        send_request(CMD_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 14'h3FFF,  9'd0);
        send_request(CMD_INSERT, 16'h0000, 32'h0000_0000, 14'd0,     9'd0);
        send_request(CMD_INSERT, 16'h1234, 32'h0000_0000, 14'd10000, 9'd0);
        send_request(CMD_INSERT, 16'h8000, 32'hFFFF_FFFF, 14'd10001, 9'd0);
        send_request(CMD_INSERT, 16'h5555, 32'h8000_0000, 14'h2AAA,  9'd0);
        send_request(CMD_INSERT, 16'hAAAA, 32'h7FFF_FFFF, 14'h1555,  9'd0);
        send_request(CMD_INSERT, 16'h1234, 32'h0000_0001, 14'd1,     9'd0);
        send_request(CMD_FIND,   16'h1234, 32'h0,         14'd0,     9'd0);
        send_request(CMD_FIND,   16'hFFFF, 32'h0,         14'd0,     9'd0);
        send_request(CMD_FIND,   16'h0000, 32'h0,         14'd0,     9'd0);
        send_request(CMD_FIND,   16'h4321, 32'h0,         14'd0,     9'd0);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd0);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd1);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd7);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd8);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd511);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd256);
        send_request(CMD_CLEAR,  16'h0000, 32'h0,         14'd0,     9'd0);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd1);
        send_request(CMD_FIND,   16'hFFFF, 32'h0,         14'd0,     9'd0);
        send_request(CMD_INSERT, 16'h00FF, 32'h0000_0005, 14'd9999,  9'd0);
        send_request(CMD_READ,   16'h0000, 32'h0,         14'd0,     9'd1);
        finish_phase();
    endtask

    // Fill every entry, then push past full and probe the last rank
    task automatic test_full_table();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(CMD_CLEAR, 16'h0, 32'h0, 14'd0, 9'd0);
        repeat (ENTRIES)
            send_request(CMD_INSERT, 16'($urandom), 32'($urandom_range(63)),
                         14'($urandom_range(10000)), 9'd0);
        send_request(CMD_INSERT, 16'h7777, 32'hFFFF_FFFF, 14'd5000, 9'd0);
        send_request(CMD_INSERT, 16'h7778, 32'h0,         14'd5000, 9'd0);
        send_request(CMD_READ,   16'h0,    32'h0,         14'd0,    9'(ENTRIES));
        send_request(CMD_READ,   16'h0,    32'h0,         14'd0,    9'(ENTRIES + 1));
        send_request(CMD_FIND,   PID_W'(rec_id[ENTRIES-1]), 32'h0, 14'd0, 9'd0);
        send_request(CMD_FIND,   16'($urandom), 32'h0,    14'd0,    9'd0);
        send_request(CMD_READ,   16'h0,    32'h0,         14'd0,    9'd1);
        send_request(CMD_CLEAR,  16'h0,    32'h0,         14'd0,    9'd0);
        finish_phase();
    endtask

    task automatic test_random(int n, int idle_pct, int stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n)
            send_random_request();
        finish_phase();
    endtask

    // Receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = HOLD_CYCLES;
        repeat (8)
            send_random_request();
        finish_phase();
    endtask

    // Result side: random ready, compare each accepted result with the oldest expectation
    initial begin
        t_outcome want_res;
        forever begin
            @(posedge i_clk);
            if (recv_hold_left > 0) begin
                i_out_ready <= 1'b0;
                recv_hold_left--;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
            @(negedge i_clk);
            if (o_out_valid && i_out_ready) begin
                if (pending_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: status %0d rank %0d count %0d",
                                 o_status, o_rank, o_count);
                end else begin
                    want_res = pending_outcomes.pop_front();
                    status_seen[want_res.status]++;
                    if (o_status !== want_res.status || o_rank !== want_res.rank ||
                        o_count !== want_res.count || o_entry_id !== want_res.id ||
                        o_entry_login !== want_res.login ||
                        o_entry_percent !== want_res.pct) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS) begin
                            $display("mismatch: expected st %0d rank %0d cnt %0d id %h lg %h pc %0d",
                                     want_res.status, want_res.rank, want_res.count,
                                     want_res.id, want_res.login, want_res.pct);
                            $display("          got      st %0d rank %0d cnt %0d id %h lg %h pc %0d",
                                     o_status, o_rank, o_count, o_entry_id,
                                     o_entry_login, o_entry_percent);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: too long without any request or result moving
    always @(negedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_run = 0;
        end else if (i_rst_n) begin
            idle_run++;
            if (idle_run >= STALL_LIMIT) begin
                $display("watchdog: %0d cycles without progress", idle_run);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_random(320, 0, 0);
        test_random(320, 85, 0);
        test_random(320, 0, 85);
        test_random(320, 36, 36);
        test_backpressure();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("requests: %0d clear, %0d insert, %0d find, %0d read",
                 cmd_sent[CMD_CLEAR], cmd_sent[CMD_INSERT], cmd_sent[CMD_FIND],
                 cmd_sent[CMD_READ]);
        $display("results: %0d ok, %0d full, %0d not found, %0d out of range; %0d mismatches",
                 status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_NOT_FOUND],
                 status_seen[ST_RANGE], mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== ranked_insertion_list_unit.f =====
design/ril_pkg.sv
design/ril_datapath.sv
design/ril_ctrl.sv
design/ranked_insertion_list_unit.sv
dv/ranked_insertion_list_unit_test.sv
